### hdl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	`ASSERT_CLK(label, clk, rst_n, !(cond))

`endif

### hdl/lbsg_pkg.sv
`default_nettype none
package lbsg_pkg;

	// field widths of the query and result beats
	localparam int WIN_W   = 13;
	localparam int FRAME_W = 10;
	localparam int ISC_W   = 6;
	localparam int RX_W    = 12;

	// internal widths
	localparam int SC_W = 7;   // integer scale before masking
	localparam int FW_W = 12;  // framebuffer width before masking
	localparam int PA_W = 24;  // window width times frame height, plus rounding
	localparam int PB_W = 25;  // window height times framebuffer width, plus rounding
	localparam int RI_W = 19;  // integer-mode rectangle products
	localparam int SN_W = 19;  // bar shift numerator

	typedef struct packed {
		logic [WIN_W-1:0] window_width;
		logic [WIN_W-1:0] window_height;
	} query_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_width;
		logic [ISC_W-1:0]   int_scale;
		logic [RX_W-1:0]    rect_x;
		logic [WIN_W-1:0]   rect_y;
		logic [WIN_W-1:0]   rect_w;
		logic [WIN_W-1:0]   rect_h;
	} result_t;

endpackage
`default_nettype wire

### hdl/lbsg_stream_if.sv
`default_nettype none
interface lbsg_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/lbsg_div.sv
`default_nettype none
// pipelined restoring divider, one quotient bit per stage
module lbsg_div #(
	parameter int NW = 24,
	parameter int DW = 13,
	parameter int SW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [SW-1:0] side,
	output logic               out_valid,
	output logic [NW-1:0]      quo,
	output logic [SW-1:0]      side_out
);

	logic          vld_s  [NW+1];
	logic [NW-1:0] num_s  [NW+1];
	logic [DW-1:0] rem_s  [NW+1];
	logic [NW-1:0] quo_s  [NW+1];
	logic [DW-1:0] den_s  [NW+1];
	logic [SW-1:0] side_s [NW+1];

	assign vld_s[0]  = in_valid;
	assign num_s[0]  = num;
	assign rem_s[0]  = '0;
	assign quo_s[0]  = '0;
	assign den_s[0]  = den;
	assign side_s[0] = side;

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic        fits;

		assign trial = {rem_s[k], num_s[k][NW-1]};
		assign diff  = trial - {1'b0, den_s[k]};
		assign fits  = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= fits ? diff[DW-1:0] : trial[DW-1:0];
				num_s[k+1]  <= num_s[k] << 1;
				quo_s[k+1]  <= {quo_s[k][NW-2:0], fits};
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[NW];
	assign quo       = quo_s[NW];
	assign side_out  = side_s[NW];

endmodule
`default_nettype wire

### hdl/letterbox_scale_geometry.sv
// throughput: one query per cycle while the output queue has a free slot, set by the two
// divider pipelines (24 and 25 stages) that advance together with the stage registers;
// divisions by constants use reciprocals
// a two-beat output queue takes results while the consumer stalls
// reset: arst_n clears valid bits, queue pointers and fit_mode (integer scale)
`default_nettype none
module letterbox_scale_geometry
	import lbsg_pkg::*;
#(
	parameter int BASE_WIDTH      = 320,
	parameter int FRAME_HEIGHT    = 200,
	parameter int MAX_WIDTH       = 512,
	parameter int TOP_BAR_ROWS    = 16,
	parameter int BOTTOM_BAR_ROWS = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_we,
	input  wire logic      cfg_wdata,
	lbsg_stream_if.sink    query,
	lbsg_stream_if.source  result
);

	// half the bar difference, truncated toward zero, kept as sign and magnitude
	localparam int SH     = (BOTTOM_BAR_ROWS - TOP_BAR_ROWS) / 2;
	localparam bit SH_NEG = SH < 0;
	localparam int SH_ABS = SH_NEG ? -SH : SH;
	localparam int QDEPTH = 2;

	// reciprocals for the divisions by constants, exact for every numerator of the field
	localparam int     PR_W = 2 * WIN_W + 2;
	localparam int     KW   = WIN_W + $clog2(BASE_WIDTH);
	localparam longint MW   = ((longint'(1) << KW) + longint'(BASE_WIDTH) - 1)
	                          / longint'(BASE_WIDTH);
	localparam int     KH   = WIN_W + $clog2(FRAME_HEIGHT);
	localparam longint MH   = ((longint'(1) << KH) + longint'(FRAME_HEIGHT) - 1)
	                          / longint'(FRAME_HEIGHT);
	// shift numerator is the bar magnitude times the height, folded into one constant
	localparam int     SP_W = WIN_W + SN_W + 8;
	localparam int     KS   = SN_W + $clog2(FRAME_HEIGHT);
	localparam longint MS   = ((longint'(1) << KS) + longint'(FRAME_HEIGHT) - 1)
	                          / longint'(FRAME_HEIGHT);
	localparam longint MSS  = longint'(SH_ABS) * MS;

	// context carried alongside the dividers
	typedef struct packed {
		logic [WIN_W-1:0] ww;
		logic [WIN_W-1:0] wh;
		logic [SC_W-1:0]  sc;
		logic             intm;
		logic [PA_W-1:0]  pa;
	} ctx2_t;

	typedef struct packed {
		logic [WIN_W-1:0] ww;
		logic [WIN_W-1:0] wh;
		logic [SC_W-1:0]  sc;
		logic             intm;
		logic             byw;
		logic [RI_W-1:0]  rwi;
		logic [RI_W-1:0]  rhi;
		logic [FW_W-1:0]  fw;
	} ctx3_t;

	typedef struct packed {
		logic [WIN_W-1:0] ww;
		logic [WIN_W-1:0] wh;
		logic [SC_W-1:0]  sc;
		logic [FW_W-1:0]  fw;
		logic [WIN_W-1:0] rw;
		logic [WIN_W-1:0] rh;
	} ctx4_t;

	// configuration
	logic fit_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= 1'b0;
		end else if (cfg_we) begin
			fit_mode_q <= cfg_wdata;
		end
	end

	// the whole pipeline moves while the output queue has a free slot
	logic [1:0] qcnt_q;
	logic       adv;

	assign adv         = qcnt_q != 2'(QDEPTH);
	assign query.ready = adv;

	// stage 1: unknown size falls back to the base size, reciprocal products
	logic             vld_s1;
	logic [WIN_W-1:0] ww_s1, wh_s1;
	logic [PR_W-1:0]  pw_s1, ph_s1;
	logic             unknown;
	logic [WIN_W-1:0] ww_sel, wh_sel;

	assign unknown = (query.data.window_width == '0) || (query.data.window_height == '0);
	assign ww_sel  = unknown ? WIN_W'(BASE_WIDTH) : query.data.window_width;
	assign wh_sel  = unknown ? WIN_W'(FRAME_HEIGHT) : query.data.window_height;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= query.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ww_s1 <= ww_sel;
			wh_s1 <= wh_sel;
			pw_s1 <= PR_W'(ww_sel) * PR_W'(MW);
			ph_s1 <= PR_W'(wh_sel) * PR_W'(MH);
		end
	end

	// how many base pictures fit across and down
	logic [WIN_W-1:0] qw, qh;

	assign qw = WIN_W'(pw_s1 >> KW);
	assign qh = WIN_W'(ph_s1 >> KH);

	// stage 2: scale is the smaller count, integer mode needs at least 1x
	logic             vld_s2;
	ctx2_t            c_s2;
	logic [WIN_W-1:0] sc_min;

	assign sc_min = (qw < qh) ? qw : qh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s2.ww   <= ww_s1;
			c_s2.wh   <= wh_s1;
			c_s2.sc   <= sc_min[SC_W-1:0];
			c_s2.intm <= !fit_mode_q && (sc_min != '0);
			c_s2.pa   <= PA_W'(ww_s1) * PA_W'(FRAME_HEIGHT);
		end
	end

	// framebuffer width: window width over scale, or aspect-matched with rounding
	logic [PA_W-1:0]  num2;
	logic [WIN_W-1:0] den2;
	logic             d2_v;
	logic [PA_W-1:0]  q2;
	logic [$bits(ctx2_t)-1:0] side2;
	ctx2_t            c_d2;

	assign num2 = c_s2.intm ? PA_W'(c_s2.ww) : c_s2.pa + PA_W'(c_s2.wh >> 1);
	assign den2 = c_s2.intm ? WIN_W'(c_s2.sc) : c_s2.wh;

	lbsg_div #(.NW(PA_W), .DW(WIN_W), .SW($bits(ctx2_t))) u_div_frame (
		.clk, .arst_n, .en(adv), .in_valid(vld_s2),
		.num(num2), .den(den2), .side(c_s2),
		.out_valid(d2_v), .quo(q2), .side_out(side2)
	);

	assign c_d2 = side2;

	// stage 3: clamp to base, then to maximum, align down to 8
	logic             vld_s3;
	logic [PA_W-1:0]  fw_lo;
	logic [PA_W-1:0]  fw_clamp;
	logic [WIN_W-1:0] ww_s3, wh_s3;
	logic [SC_W-1:0]  sc_s3;
	logic             intm_s3;
	logic [PA_W-1:0]  pa_s3;
	logic [FW_W-1:0]  fw_s3;

	always_comb begin
		fw_lo    = (q2 < PA_W'(BASE_WIDTH)) ? PA_W'(BASE_WIDTH) : q2;
		fw_clamp = (fw_lo > PA_W'(MAX_WIDTH)) ? PA_W'(MAX_WIDTH) : fw_lo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= d2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ww_s3   <= c_d2.ww;
			wh_s3   <= c_d2.wh;
			sc_s3   <= c_d2.intm ? c_d2.sc : '0;
			intm_s3 <= c_d2.intm;
			pa_s3   <= c_d2.pa;
			fw_s3   <= {fw_clamp[FW_W-1:3], 3'b000};
		end
	end

	// stage 4: products for both fit directions and for integer mode
	logic             vld_s4;
	logic [WIN_W-1:0] ww_s4, wh_s4;
	logic [SC_W-1:0]  sc_s4;
	logic             intm_s4;
	logic [PA_W-1:0]  pa_s4;
	logic [PB_W-1:0]  pb_s4;
	logic [RI_W-1:0]  rwi_s4, rhi_s4;
	logic [FW_W-1:0]  fw_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ww_s4   <= ww_s3;
			wh_s4   <= wh_s3;
			sc_s4   <= sc_s3;
			intm_s4 <= intm_s3;
			pa_s4   <= pa_s3;
			pb_s4   <= PB_W'(wh_s3) * PB_W'(fw_s3);
			rwi_s4  <= RI_W'(fw_s3) * RI_W'(sc_s3);
			rhi_s4  <= RI_W'(FRAME_HEIGHT) * RI_W'(sc_s3);
			fw_s4   <= fw_s3;
		end
	end

	// fit by width when the window is relatively taller, else by height
	logic             byw;
	logic [PB_W-1:0]  num3;
	logic [WIN_W-1:0] den3;
	ctx3_t            c_in3, c_d3;
	logic             d3_v;
	logic [PB_W-1:0]  q3;
	logic [$bits(ctx3_t)-1:0] side3;

	assign byw  = PB_W'(pa_s4) <= pb_s4;
	assign num3 = byw ? PB_W'(pa_s4) + PB_W'(fw_s4 >> 1)
	                  : pb_s4 + PB_W'(FRAME_HEIGHT / 2);
	assign den3 = byw ? WIN_W'(fw_s4) : WIN_W'(FRAME_HEIGHT);

	always_comb begin
		c_in3.ww   = ww_s4;
		c_in3.wh   = wh_s4;
		c_in3.sc   = sc_s4;
		c_in3.intm = intm_s4;
		c_in3.byw  = byw;
		c_in3.rwi  = rwi_s4;
		c_in3.rhi  = rhi_s4;
		c_in3.fw   = fw_s4;
	end

	lbsg_div #(.NW(PB_W), .DW(WIN_W), .SW($bits(ctx3_t))) u_div_fit (
		.clk, .arst_n, .en(adv), .in_valid(vld_s4),
		.num(num3), .den(den3), .side(c_in3),
		.out_valid(d3_v), .quo(q3), .side_out(side3)
	);

	assign c_d3 = side3;

	// stage 5: pick rectangle size, clamp to the window, at least 1
	logic             vld_s5;
	ctx4_t            c_s5;
	logic [PB_W-1:0]  rw_raw, rh_raw;
	logic [WIN_W-1:0] rw_lim, rh_lim;

	always_comb begin
		priority if (c_d3.intm) begin
			rw_raw = PB_W'(c_d3.rwi);
			rh_raw = PB_W'(c_d3.rhi);
		end else if (c_d3.byw) begin
			rw_raw = PB_W'(c_d3.ww);
			rh_raw = q3;
		end else begin
			rw_raw = q3;
			rh_raw = PB_W'(c_d3.wh);
		end
		rw_lim = (rw_raw > PB_W'(c_d3.ww)) ? c_d3.ww : rw_raw[WIN_W-1:0];
		rh_lim = (rh_raw > PB_W'(c_d3.wh)) ? c_d3.wh : rh_raw[WIN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= d3_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s5.ww <= c_d3.ww;
			c_s5.wh <= c_d3.wh;
			c_s5.sc <= c_d3.sc;
			c_s5.fw <= c_d3.fw;
			c_s5.rw <= (rw_lim == '0) ? WIN_W'(1) : rw_lim;
			c_s5.rh <= (rh_lim == '0) ? WIN_W'(1) : rh_lim;
		end
	end

	// stage 6: bar shift in fit mode scales with the rectangle height
	logic             vld_s6;
	ctx4_t            c_s6;
	logic [SP_W-1:0]  sp_s6;
	logic [SN_W-1:0]  q4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s6  <= c_s5;
			sp_s6 <= SP_W'(c_s5.rh) * SP_W'(MSS);
		end
	end

	assign q4 = SN_W'(sp_s6 >> KS);

	// centre, shift by the bar difference, keep inside the room below and above
	logic [SN_W-1:0]        mag;
	logic [WIN_W-1:0]       room;
	logic signed [SN_W+1:0] ry_sh;
	logic [WIN_W-1:0]       ry_fin;
	result_t                res;

	always_comb begin
		mag   = (c_s6.sc != '0) ? SN_W'(SH_ABS) * SN_W'(c_s6.sc) : q4;
		room  = c_s6.wh - c_s6.rh;
		ry_sh = signed'((SN_W+2)'(room >> 1));
		if (SH_NEG) begin
			ry_sh = ry_sh - signed'((SN_W+2)'(mag));
		end else begin
			ry_sh = ry_sh + signed'((SN_W+2)'(mag));
		end
		priority if (ry_sh > signed'((SN_W+2)'(room))) begin
			ry_fin = room;
		end else if (ry_sh < 0) begin
			ry_fin = '0;
		end else begin
			ry_fin = ry_sh[WIN_W-1:0];
		end
		res.frame_width = c_s6.fw[FRAME_W-1:0];
		res.int_scale   = c_s6.sc[ISC_W-1:0];
		res.rect_x      = RX_W'((c_s6.ww - c_s6.rw) >> 1);
		res.rect_y      = ry_fin;
		res.rect_w      = c_s6.rw;
		res.rect_h      = c_s6.rh;
	end

	// output queue, two beats deep
	result_t    qmem_q [QDEPTH];
	logic       wr_ptr_q, rd_ptr_q;
	logic       push, pop;

	assign push = adv && vld_s6;
	assign pop  = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			qcnt_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			qcnt_q <= qcnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			qmem_q[wr_ptr_q] <= res;
		end
	end

	assign result.valid = qcnt_q != '0;
	assign result.data  = qmem_q[rd_ptr_q];

endmodule
`default_nettype wire

### hdl/lbsg_checker.sv
`default_nettype none
`include "assert_macros.svh"
module lbsg_checker
	import lbsg_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    rsp_valid,
	input wire logic    rsp_ready,
	input wire result_t rsp_data
);

	// a stalled result beat stays offered and unchanged
	`ASSERT_CLK(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid)
	`ASSERT_CLK(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready |=> $stable(rsp_data))

	// framebuffer width stays aligned to 8
	`ASSERT_NEVER(a_fw_align, clk, arst_n, rsp_valid && (rsp_data.frame_width[2:0] != 3'b000))

	// rectangle never collapses
	`ASSERT_NEVER(a_rect_size, clk, arst_n,
		rsp_valid && ((rsp_data.rect_w == '0) || (rsp_data.rect_h == '0)))

endmodule

bind letterbox_scale_geometry lbsg_checker u_lbsg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (result.valid),
	.rsp_ready (result.ready),
	.rsp_data  (result.data)
);
`default_nettype wire

### bench/tb.sv
`default_nettype none
module tb;
	import lbsg_pkg::*;

	localparam int BASE_W    = 320;
	localparam int FRAME_H   = 200;
	localparam int MAX_W     = 512;
	localparam int TOP_ROWS  = 16;
	localparam int BOT_ROWS  = 32;
	localparam int LATENCY   = 56;

	// fit mode register values
	localparam logic MODE_INTEGER = 1'b0;
	localparam logic MODE_ASPECT  = 1'b1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	lbsg_stream_if #(.T(query_t))  query_bus ();
	lbsg_stream_if #(.T(result_t)) result_bus ();

	letterbox_scale_geometry u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.query     (query_bus.sink),
		.result    (result_bus.source)
	);

	always #5 clk = ~clk;

	// fit mode as the block sees it, tracked on our side
	logic mode_shadow = MODE_INTEGER;

	query_t  pending_queries[$];
	result_t expected_geometry[$];

	int  mismatch_count = 0;
	bit  calm = 1'b0;      // no idling on either side during this stretch
	bit  hold_sender = 1'b0;

	// clamp to base and max width, then align down to eight
	function automatic longint clamp_frame(longint w);
		if (w < BASE_W) w = BASE_W;
		if (w > MAX_W) w = MAX_W;
		return w - (w % 8);
	endfunction

	function automatic result_t fit_geometry(query_t q, logic mode);
		longint ww, wh, fw, sc, rw, rh, rx, ry, shift;
		result_t r;
		ww = q.window_width;
		wh = q.window_height;
		// unknown window size falls back to the base picture
		if (ww < 1 || wh < 1) begin
			ww = BASE_W;
			wh = FRAME_H;
		end
		sc = wh / FRAME_H;
		if (ww / BASE_W < sc) sc = ww / BASE_W;
		if (mode == MODE_INTEGER && sc >= 1) begin
			fw = clamp_frame(ww / sc);
			rw = fw * sc;
			rh = FRAME_H * sc;
		end else begin
			// aspect-matched width, then fit by width or by height
			fw = clamp_frame((ww * FRAME_H + wh / 2) / wh);
			sc = 0;
			if (ww * FRAME_H <= wh * fw) begin
				rw = ww;
				rh = (ww * FRAME_H + fw / 2) / fw;
			end else begin
				rh = wh;
				rw = (wh * fw + FRAME_H / 2) / FRAME_H;
			end
		end
		if (rw > ww) rw = ww;
		if (rh > wh) rh = wh;
		if (rw < 1) rw = 1;
		if (rh < 1) rh = 1;
		rx = (ww - rw) / 2;
		ry = (wh - rh) / 2;
		// bar difference shift, truncated toward zero, bounded by the room below and above
		shift = (longint'(BOT_ROWS) - longint'(TOP_ROWS)) / 2;
		if (sc > 0) shift = shift * sc;
		else shift = (shift * rh) / FRAME_H;
		ry = ry + shift;
		if (ry > wh - rh) ry = wh - rh;
		if (ry < 0) ry = 0;
		r.frame_width   = fw[FRAME_W-1:0];
		r.int_scale     = sc[ISC_W-1:0];
		r.rect_x        = rx[RX_W-1:0];
		r.rect_y        = ry[WIN_W-1:0];
		r.rect_w        = rw[WIN_W-1:0];
		r.rect_h        = rh[WIN_W-1:0];
		return r;
	endfunction

	function automatic query_t make_query(int w, int h);
		query_t q;
		q.window_width  = w[WIN_W-1:0];
		q.window_height = h[WIN_W-1:0];
		return q;
	endfunction

	// random window: half realistic sizes, the rest small, zero or anywhere in the field range
	function automatic query_t random_query();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 5)
			return make_query($urandom_range(200, 4000), $urandom_range(150, 2400));
		else if (pick < 7)
			return make_query($urandom_range(0, 700), $urandom_range(0, 450));
		else if (pick == 7)
			return make_query($urandom_range(0, 1) ? 0 : $urandom_range(0, 8191),
				$urandom_range(0, 1) ? 0 : $urandom_range(0, 8191));
		else
			return make_query($urandom_range(0, 8191), $urandom_range(0, 8191));
	endfunction

	// driver: a beat leaves the queue at the edge that accepts it,
	// the next one is set up on the falling edge
	initial begin
		query_bus.valid = 1'b0;
		query_bus.data  = '0;
		result_bus.ready = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && query_bus.valid && query_bus.ready) begin
			expected_geometry.push_back(fit_geometry(query_bus.data, mode_shadow));
			void'(pending_queries.pop_front());
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (pending_queries.size() > 0 && !hold_sender
				&& (calm || $urandom_range(0, 99) >= 11)) begin
				query_bus.valid <= 1'b1;
				query_bus.data  <= pending_queries[0];
			end else begin
				query_bus.valid <= 1'b0;
			end
			result_bus.ready <= calm || $urandom_range(0, 99) >= 11;
		end
	end

	// monitor: compare each result beat with the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (expected_geometry.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result beat %p", result_bus.data);
			end else begin
				want = expected_geometry.pop_front();
				if (result_bus.data !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected %p actual %p", want, result_bus.data);
				end
			end
		end
	end

	// wait until the driver has handed over every beat and all results are back
	task automatic drain();
		while (pending_queries.size() > 0 || query_bus.valid || expected_geometry.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_mode(logic value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		mode_shadow = value;
	endtask

	task automatic directed_set();
		pending_queries.push_back(make_query(0, 0));
		pending_queries.push_back(make_query(0, 8191));
		pending_queries.push_back(make_query(8191, 0));
		pending_queries.push_back(make_query(8191, 8191));
		pending_queries.push_back(make_query(1, 1));
		pending_queries.push_back(make_query(320, 200));
		pending_queries.push_back(make_query(319, 199));
		pending_queries.push_back(make_query(640, 400));
		pending_queries.push_back(make_query(1280, 800));
		pending_queries.push_back(make_query(1920, 1080));
		pending_queries.push_back(make_query(1280, 720));
		pending_queries.push_back(make_query(8191, 1));
		pending_queries.push_back(make_query(1, 8191));
		pending_queries.push_back(make_query(5461, 2730));
		pending_queries.push_back(make_query(4096, 4096));
		pending_queries.push_back(make_query(800, 200));
		pending_queries.push_back(make_query(320, 8000));
	endtask

	task automatic random_set(int count);
		repeat (count) pending_queries.push_back(random_query());
		while (pending_queries.size() > 0) @(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// integer mode straight from reset
		directed_set();
		drain();
		write_mode(MODE_ASPECT);
		directed_set();
		drain();
		write_mode(MODE_INTEGER);

		random_set(250);
		// sender holds off until every result is back
		hold_sender = 1'b1;
		while (expected_geometry.size() > 0) @(posedge clk);
		hold_sender = 1'b0;
		calm = 1'b1;
		random_set(200);
		calm = 1'b0;
		drain();

		write_mode(MODE_ASPECT);
		random_set(300);
		drain();
		write_mode(MODE_INTEGER);
		random_set(300);
		drain();

		if (mismatch_count == 0 && expected_geometry.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// watchdog well beyond the slowest correct run
	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
